/* rtl/core/bary_pkg.sv */
// shared types and constants for the barycentric weight pipeline
// no dependencies; imported by barycentric_coordinates
package bary_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int WEIGHT_FRAC_BITS = 30;
  localparam int WEIGHT_WIDTH     = 32;

  localparam int DIFF_W    = COORD_WIDTH + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int HALF_W    = SUM_W / 2;
  localparam int PART_W    = SUM_W + HALF_W + 1;
  localparam int FULL_W    = 2 * SUM_W;
  localparam int NUM_W     = FULL_W + 2;
  localparam int DIV_SHIFT = WEIGHT_WIDTH - WEIGHT_FRAC_BITS;
  localparam int REM_W     = NUM_W + DIV_SHIFT + 1;
  localparam int DIV_STEPS = WEIGHT_WIDTH;
  localparam int LANES     = 3;
  localparam int PRODUCTS  = 6;

  localparam int LANE_U = 0;
  localparam int LANE_V = 1;
  localparam int LANE_W = 2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] vert_a_x;
    logic signed [COORD_WIDTH-1:0] vert_a_y;
    logic signed [COORD_WIDTH-1:0] vert_a_z;
    logic signed [COORD_WIDTH-1:0] vert_b_x;
    logic signed [COORD_WIDTH-1:0] vert_b_y;
    logic signed [COORD_WIDTH-1:0] vert_b_z;
    logic signed [COORD_WIDTH-1:0] vert_c_x;
    logic signed [COORD_WIDTH-1:0] vert_c_y;
    logic signed [COORD_WIDTH-1:0] vert_c_z;
  } bary_in_t;

  typedef struct packed {
    logic signed [WEIGHT_WIDTH-1:0] weight_u;
    logic signed [WEIGHT_WIDTH-1:0] weight_v;
    logic signed [WEIGHT_WIDTH-1:0] weight_w;
    logic                           degenerate;
    logic                           saturated;
  } bary_out_t;

endpackage

/* rtl/core/barycentric_coordinates.sv */
// barycentric weights of a point against a 3d triangle, fully pipelined
// depends on bary_pkg for payload types and derived widths
//
// usage:
//   item channel (item_valid, item_stall, item) takes the point and the three
//   vertices; result channel (result_valid, result_stall, result) gives the
//   weights u, v, w in Q1.30 plus the degenerate and saturated flags.
//   an item is taken at a rising edge with valid high and stall low.
// pipeline: 41 register stages (8 arithmetic stages, one stage per quotient bit
//   of the 32-step restoring divider, and the rounding and clamp stage that holds
//   the result register), the first loaded at the accepting edge.
// throughput: one item per cycle while item_stall is low; the three divider
//   lanes run side by side and each divider stage retires one quotient bit.
// stall: each stage moves on when its successor is empty or moving, so
//   bubbles close up under a stalled result and items keep entering until
//   every stage is full; item_stall rises only then.
// reset: synchronous, clears every stage valid bit; no result is pending
//   after reset and the first item can be taken in the next cycle.
module barycentric_coordinates
  import bary_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  bary_in_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output bary_out_t result
);

  localparam int FRONT = 8;
  localparam int NS    = FRONT + DIV_STEPS + 1;

  logic [NS-1:0] v;
  logic [NS-1:0] go;

  always_comb begin
    go[NS-1] = !v[NS-1] || !result_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      go[k] = !v[k] || go[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) begin
        v[0] <= item_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (go[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign item_stall   = !go[0];
  assign result_valid = v[NS-1];

  // stage 1: edge vectors
  logic signed [DIFF_W-1:0] pt [LANES];
  logic signed [DIFF_W-1:0] va [LANES];
  logic signed [DIFF_W-1:0] vb [LANES];
  logic signed [DIFF_W-1:0] vc [LANES];
  logic signed [DIFF_W-1:0] eb [LANES];
  logic signed [DIFF_W-1:0] ec [LANES];
  logic signed [DIFF_W-1:0] ep [LANES];

  assign pt[0] = DIFF_W'(item.point_x);
  assign pt[1] = DIFF_W'(item.point_y);
  assign pt[2] = DIFF_W'(item.point_z);
  assign va[0] = DIFF_W'(item.vert_a_x);
  assign va[1] = DIFF_W'(item.vert_a_y);
  assign va[2] = DIFF_W'(item.vert_a_z);
  assign vb[0] = DIFF_W'(item.vert_b_x);
  assign vb[1] = DIFF_W'(item.vert_b_y);
  assign vb[2] = DIFF_W'(item.vert_b_z);
  assign vc[0] = DIFF_W'(item.vert_c_x);
  assign vc[1] = DIFF_W'(item.vert_c_y);
  assign vc[2] = DIFF_W'(item.vert_c_z);

  always_ff @(posedge clk) begin
    if (go[0]) begin
      for (int k = 0; k < LANES; k++) begin
        eb[k] <= vb[k] - va[k];
        ec[k] <= vc[k] - va[k];
        ep[k] <= pt[k] - va[k];
      end
    end
  end

  // stage 2: component products
  logic signed [PROD_W-1:0] pbb [LANES];
  logic signed [PROD_W-1:0] pbc [LANES];
  logic signed [PROD_W-1:0] pcc [LANES];
  logic signed [PROD_W-1:0] ppb [LANES];
  logic signed [PROD_W-1:0] ppc [LANES];

  always_ff @(posedge clk) begin
    if (go[1]) begin
      for (int k = 0; k < LANES; k++) begin
        pbb[k] <= PROD_W'(eb[k]) * PROD_W'(eb[k]);
        pbc[k] <= PROD_W'(eb[k]) * PROD_W'(ec[k]);
        pcc[k] <= PROD_W'(ec[k]) * PROD_W'(ec[k]);
        ppb[k] <= PROD_W'(ep[k]) * PROD_W'(eb[k]);
        ppc[k] <= PROD_W'(ep[k]) * PROD_W'(ec[k]);
      end
    end
  end

  // stage 3: dot products
  logic signed [SUM_W-1:0] bb, bc, cc, pb, pc;

  always_ff @(posedge clk) begin
    if (go[2]) begin
      bb <= SUM_W'(pbb[0]) + SUM_W'(pbb[1]) + SUM_W'(pbb[2]);
      bc <= SUM_W'(pbc[0]) + SUM_W'(pbc[1]) + SUM_W'(pbc[2]);
      cc <= SUM_W'(pcc[0]) + SUM_W'(pcc[1]) + SUM_W'(pcc[2]);
      pb <= SUM_W'(ppb[0]) + SUM_W'(ppb[1]) + SUM_W'(ppb[2]);
      pc <= SUM_W'(ppc[0]) + SUM_W'(ppc[1]) + SUM_W'(ppc[2]);
    end
  end

  // stage 4: half-width partial products of the six cross terms
  logic signed [SUM_W-1:0]  ma [PRODUCTS];
  logic signed [SUM_W-1:0]  mb [PRODUCTS];
  logic signed [PART_W-1:0] part_hi [PRODUCTS];
  logic signed [PART_W-1:0] part_lo [PRODUCTS];

  assign ma[0] = bb; assign mb[0] = cc;
  assign ma[1] = bc; assign mb[1] = bc;
  assign ma[2] = cc; assign mb[2] = pb;
  assign ma[3] = bc; assign mb[3] = pc;
  assign ma[4] = bb; assign mb[4] = pc;
  assign ma[5] = bc; assign mb[5] = pb;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      for (int k = 0; k < PRODUCTS; k++) begin
        part_hi[k] <= PART_W'(ma[k]) * PART_W'($signed(mb[k][SUM_W-1:HALF_W]));
        part_lo[k] <= PART_W'(ma[k]) * PART_W'($signed({1'b0, mb[k][HALF_W-1:0]}));
      end
    end
  end

  // stage 5: full cross products
  logic signed [FULL_W-1:0] full [PRODUCTS];

  always_ff @(posedge clk) begin
    if (go[4]) begin
      for (int k = 0; k < PRODUCTS; k++) begin
        full[k] <= (FULL_W'(part_hi[k]) <<< HALF_W) + FULL_W'(part_lo[k]);
      end
    end
  end

  // stage 6: determinant and numerators of v and w
  logic signed [NUM_W-1:0] den6, nv6, nw6;

  always_ff @(posedge clk) begin
    if (go[5]) begin
      den6 <= NUM_W'(full[0]) - NUM_W'(full[1]);
      nv6  <= NUM_W'(full[2]) - NUM_W'(full[3]);
      nw6  <= NUM_W'(full[4]) - NUM_W'(full[5]);
    end
  end

  // stage 7: numerator of u
  logic signed [NUM_W-1:0] den7;
  logic signed [NUM_W-1:0] num7 [LANES];

  always_ff @(posedge clk) begin
    if (go[6]) begin
      den7         <= den6;
      num7[LANE_U] <= den6 - nv6 - nw6;
      num7[LANE_V] <= nv6;
      num7[LANE_W] <= nw6;
    end
  end

  // stage 8: magnitudes, scaled divisor, degenerate test
  logic [NUM_W-1:0] mag7 [LANES];
  logic [REM_W-1:0] mag8 [LANES];
  logic             neg8 [LANES];
  logic [REM_W-1:0] e8;
  logic             degen8;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      mag7[k] = num7[k][NUM_W-1] ? NUM_W'(-num7[k]) : NUM_W'(num7[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (go[7]) begin
      for (int k = 0; k < LANES; k++) begin
        mag8[k] <= REM_W'(mag7[k]);
        neg8[k] <= num7[k][NUM_W-1];
      end
      e8     <= REM_W'(den7) << DIV_SHIFT;
      degen8 <= den7[NUM_W-1] || (den7 == '0);
    end
  end

  // restoring divider, one quotient bit per stage
  function automatic logic [REM_W:0] div_step(logic [REM_W-1:0] r, logic [REM_W-1:0] e);
    logic [REM_W-1:0] t;
    t = {r[REM_W-2:0], 1'b0};
    if (t >= e) begin
      div_step = {1'b1, t - e};
    end else begin
      div_step = {1'b0, t};
    end
  endfunction

  logic [REM_W-1:0]        drem  [DIV_STEPS][LANES];
  logic [WEIGHT_WIDTH-1:0] dquo  [DIV_STEPS][LANES];
  logic                    dbig  [DIV_STEPS][LANES];
  logic                    dneg  [DIV_STEPS][LANES];
  logic [REM_W-1:0]        de    [DIV_STEPS];
  logic                    ddeg  [DIV_STEPS];

  genvar d;
  generate
    for (d = 0; d < DIV_STEPS; d++) begin : g_div
      logic [REM_W:0] step [LANES];
      if (d == 0) begin : g_first
        always_comb begin
          for (int k = 0; k < LANES; k++) begin
            step[k] = div_step(mag8[k], e8);
          end
        end
        always_ff @(posedge clk) begin
          if (go[FRONT]) begin
            for (int k = 0; k < LANES; k++) begin
              drem[0][k] <= step[k][REM_W-1:0];
              dquo[0][k] <= WEIGHT_WIDTH'(step[k][REM_W]);
              dbig[0][k] <= mag8[k] >= e8;
              dneg[0][k] <= neg8[k];
            end
            de[0]   <= e8;
            ddeg[0] <= degen8;
          end
        end
      end else begin : g_next
        always_comb begin
          for (int k = 0; k < LANES; k++) begin
            step[k] = div_step(drem[d-1][k], de[d-1]);
          end
        end
        always_ff @(posedge clk) begin
          if (go[FRONT+d]) begin
            for (int k = 0; k < LANES; k++) begin
              drem[d][k] <= step[k][REM_W-1:0];
              dquo[d][k] <= {dquo[d-1][k][WEIGHT_WIDTH-2:0], step[k][REM_W]};
              dbig[d][k] <= dbig[d-1][k];
              dneg[d][k] <= dneg[d-1][k];
            end
            de[d]   <= de[d-1];
            ddeg[d] <= ddeg[d-1];
          end
        end
      end
    end
  endgenerate

  // rounding and clamp
  function automatic logic [WEIGHT_WIDTH:0] round_clamp(
    logic [WEIGHT_WIDTH-1:0] q,
    logic [REM_W-1:0]        r,
    logic [REM_W-1:0]        e,
    logic                    neg,
    logic                    big
  );
    logic                    rnd;
    logic [WEIGHT_WIDTH:0]   qf;
    logic [WEIGHT_WIDTH:0]   nq;
    logic [WEIGHT_WIDTH:0]   limit;
    rnd   = {r, 1'b0} >= {1'b0, e};
    qf    = {1'b0, q} + (WEIGHT_WIDTH+1)'(rnd);
    nq    = ~qf + 1'b1;
    limit = (WEIGHT_WIDTH+1)'(1) << (WEIGHT_WIDTH - 1);
    if (neg) begin
      if (big || qf > limit) begin
        round_clamp = {1'b1, 1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
      end else begin
        round_clamp = {1'b0, nq[WEIGHT_WIDTH-1:0]};
      end
    end else begin
      if (big || qf >= limit) begin
        round_clamp = {1'b1, 1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
      end else begin
        round_clamp = {1'b0, qf[WEIGHT_WIDTH-1:0]};
      end
    end
  endfunction

  localparam int LAST = DIV_STEPS - 1;

  logic [WEIGHT_WIDTH:0] fin [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      fin[k] = round_clamp(dquo[LAST][k], drem[LAST][k], de[LAST], dneg[LAST][k],
                           dbig[LAST][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (go[NS-1]) begin
      if (ddeg[LAST]) begin
        result.weight_u   <= '0;
        result.weight_v   <= '0;
        result.weight_w   <= '0;
        result.degenerate <= 1'b1;
        result.saturated  <= 1'b0;
      end else begin
        result.weight_u   <= fin[LANE_U][WEIGHT_WIDTH-1:0];
        result.weight_v   <= fin[LANE_V][WEIGHT_WIDTH-1:0];
        result.weight_w   <= fin[LANE_W][WEIGHT_WIDTH-1:0];
        result.degenerate <= 1'b0;
        result.saturated  <= fin[LANE_U][WEIGHT_WIDTH] || fin[LANE_V][WEIGHT_WIDTH] ||
                             fin[LANE_W][WEIGHT_WIDTH];
      end
    end
  end

  // checks
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |->
      result.weight_u == '0 && result.weight_v == '0 && result.weight_w == '0 &&
      !result.saturated)
    else $error("degenerate result with nonzero weights or saturation");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("input stalled while result register empty");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule
